@@ hw/rtl/pbsc_pkg.sv @@
// ----------------------------------------------------------------------------
// pbsc_pkg
// Shared types and constants of the paged buffer with shadow commit.
// ----------------------------------------------------------------------------
`default_nettype none

package pbsc_pkg;

   localparam int ADDR_W     = 16;
   localparam int PAGE_SIZE  = 64;
   localparam int PAGE_BITS  = $clog2(PAGE_SIZE);
   localparam int RAM_SLOTS  = 8;
   localparam int SLOT_BITS  = (RAM_SLOTS > 1) ? $clog2(RAM_SLOTS) : 1;
   localparam int PAGES      = 256;
   localparam int IDX_BITS   = $clog2(PAGES);
   localparam int CNT_BITS   = IDX_BITS + 1;

   // operation codes
   localparam logic [1:0] OP_READ   = 2'd0;
   localparam logic [1:0] OP_WRITE  = 2'd1;
   localparam logic [1:0] OP_COMMIT = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_COPY   = 2'd0;
   localparam logic [1:0] KIND_XLATE  = 2'd1;
   localparam logic [1:0] KIND_COMMIT = 2'd2;

   // register indexes
   localparam logic [1:0] REG_PERSIST_BASE = 2'd0;
   localparam logic [1:0] REG_BANK_OFFSET  = 2'd1;
   localparam logic [1:0] REG_RAM_BASE     = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_NEW_RD,
      ST_VIC_RD,
      ST_WB,
      ST_FETCH,
      ST_XLATE,
      ST_CMT_RD,
      ST_CMT_PG,
      ST_CMT_WR,
      ST_CMT_DONE
   } pbsc_state_type;

   // lookup status from the slot table
   typedef struct packed {
      logic [RAM_SLOTS-1:0] hit_vec;
      logic                 hit;
      logic [SLOT_BITS-1:0] hit_slot;
      logic [SLOT_BITS-1:0] victim;
      logic [ADDR_W-1:0]    victim_tag;
      logic                 victim_dirty;
   } pbsc_slot_stat_type;

   // update commands to the slot table
   typedef struct packed {
      logic                 mark_dirty;
      logic [SLOT_BITS-1:0] mark_slot;
      logic                 fill;
      logic                 fill_dirty;
   } pbsc_slot_upd_type;

endpackage

`default_nettype wire

@@ hw/rtl/pbsc_ram.sv @@
// ----------------------------------------------------------------------------
// pbsc_ram
// Generic synchronous RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pbsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int ABITS = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [ABITS-1:0] waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [ABITS-1:0] raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/pbsc_slot_table.sv @@
// ----------------------------------------------------------------------------
// pbsc_slot_table
// Page tags, valid and dirty bits of the RAM slots, with round-robin victim.
// ----------------------------------------------------------------------------
`default_nettype none

module pbsc_slot_table (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [pbsc_pkg::ADDR_W-1:0]      lookup_tag,
   input  wire pbsc_pkg::pbsc_slot_upd_type      upd,
   output pbsc_pkg::pbsc_slot_stat_type          stat
);

   logic [pbsc_pkg::ADDR_W-1:0]    tag_ff   [pbsc_pkg::RAM_SLOTS];
   logic [pbsc_pkg::RAM_SLOTS-1:0] valid_ff;
   logic [pbsc_pkg::RAM_SLOTS-1:0] dirty_ff;
   logic [pbsc_pkg::SLOT_BITS-1:0] ptr_ff;
   logic [pbsc_pkg::SLOT_BITS-1:0] ptr_in;

   // compare all slots in parallel
   always_comb begin
      stat.hit_vec  = '0;
      stat.hit      = 1'b0;
      stat.hit_slot = '0;
      for (int k = 0; k < pbsc_pkg::RAM_SLOTS; k++) begin
         stat.hit_vec[k] = valid_ff[k] && (tag_ff[k] == lookup_tag);
         if (stat.hit_vec[k]) begin
            stat.hit      = 1'b1;
            stat.hit_slot = pbsc_pkg::SLOT_BITS'(k);
         end
      end
      stat.victim       = ptr_ff;
      stat.victim_tag   = tag_ff[ptr_ff];
      stat.victim_dirty = valid_ff[ptr_ff] && dirty_ff[ptr_ff];
   end

   // advance the pointer with wrap
   always_comb begin
      if (ptr_ff == pbsc_pkg::SLOT_BITS'(pbsc_pkg::RAM_SLOTS - 1)) begin
         ptr_in = '0;
      end else begin
         ptr_in = ptr_ff + 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         dirty_ff <= '0;
         ptr_ff   <= '0;
      end else begin
         if (upd.mark_dirty) begin
            dirty_ff[upd.mark_slot] <= 1'b1;
         end
         if (upd.fill) begin
            valid_ff[ptr_ff] <= 1'b1;
            dirty_ff[ptr_ff] <= upd.fill_dirty;
            ptr_ff           <= ptr_in;
         end
      end
   end

   // tags
   always_ff @(posedge clock) begin
      if (upd.fill) begin
         tag_ff[ptr_ff] <= lookup_tag;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/paged_buffer_with_shadow_commit.sv @@
// ----------------------------------------------------------------------------
// paged_buffer_with_shadow_commit
// Page buffer translation with dirty write-back to spare banks and commit.
// ----------------------------------------------------------------------------
// Hit: the translation result is registered from the lookup state; the block then
// returns to idle. Miss: 2 or 3 results (a write-back copy for a dirty victim, the
// fetch copy, the translation), one per cycle while the output is not stalled.
// Commit: per listed page a list RAM read, a page RAM read and a write, then a result.
// One item at a time; the page RAM read port sets the miss and commit time.
// Reset: synchronous; a pass clears all page RAM entries before input is taken.
`default_nettype none

module paged_buffer_with_shadow_commit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // operation[1:0], address[17:2], zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // copy_source[15:0], copy_dest[31:16],
                                         // local_address[47:32], was_hit[48], zero
   output logic [1:0]       rsp_tuser,   // result_kind[1:0]
   output logic             rsp_tlast,   // last
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam int AW = pbsc_pkg::ADDR_W;
   localparam int PB = pbsc_pkg::PAGE_BITS;
   localparam int IB = pbsc_pkg::IDX_BITS;
   localparam int CB = pbsc_pkg::CNT_BITS;
   localparam int SB = pbsc_pkg::SLOT_BITS;

   pbsc_pkg::pbsc_state_type state_ff, state_in;

   logic [AW-1:0] persist_base_ff, bank_offset_ff, ram_base_ff;
   logic [1:0]    op_ff, op_in;
   logic [AW-1:0] tag_ff, tag_in;
   logic [PB-1:0] offs_ff, offs_in;
   logic          new_listed_ff, new_listed_in;
   logic          new_bank_ff, new_bank_in;
   logic          vic_listed_ff, vic_listed_in;
   logic [AW-1:0] vic_dst_ff, vic_dst_in;
   logic [IB-1:0] pg_ff, pg_in;
   logic [CB-1:0] count_ff, count_in;
   logic [CB-1:0] walk_ff, walk_in;
   logic [IB-1:0] clr_ff, clr_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    kind_ff, kind_in;
   logic [AW-1:0] src_ff, src_in, dst_ff, dst_in, local_ff, local_in;
   logic          hit_ff, hit_in, last_ff, last_in;
   logic          emit, can_emit;

   logic          page_we, page_re;
   logic [IB-1:0] page_waddr, page_raddr;
   logic [1:0]    page_wdata, page_rdata;   // [1] listed, [0] bank select
   logic          list_we, list_re;
   logic [IB-1:0] list_waddr, list_raddr;
   logic [IB-1:0] list_wdata, list_rdata;

   pbsc_pkg::pbsc_slot_stat_type stat;
   pbsc_pkg::pbsc_slot_upd_type  upd;

   logic [AW-1:0] new_off, vic_off, vic_slot_addr, hit_slot_addr;
   logic [IB-1:0] new_idx, vic_idx;
   logic          new_aligned;

   // ---------------------------------------------------------------------------
   // submodules
   pbsc_slot_table u_slots (
      .clock      (clock),
      .reset      (reset),
      .lookup_tag (tag_ff),
      .upd        (upd),
      .stat       (stat)
   );

   pbsc_ram #(.WIDTH(2), .DEPTH(pbsc_pkg::PAGES)) u_page_ram (
      .clock (clock),
      .we    (page_we),
      .waddr (page_waddr),
      .wdata (page_wdata),
      .re    (page_re),
      .raddr (page_raddr),
      .rdata (page_rdata)
   );

   pbsc_ram #(.WIDTH(IB), .DEPTH(pbsc_pkg::PAGES)) u_list_ram (
      .clock (clock),
      .we    (list_we),
      .waddr (list_waddr),
      .wdata (list_wdata),
      .re    (list_re),
      .raddr (list_raddr),
      .rdata (list_rdata)
   );

   // ---------------------------------------------------------------------------
   // page index and slot address arithmetic
   assign new_off     = tag_ff - persist_base_ff;
   assign new_idx     = new_off[PB +: IB];
   assign new_aligned = (new_off[PB-1:0] == '0) && ((new_off >> (PB + IB)) == '0);
   assign vic_off     = stat.victim_tag - persist_base_ff;
   assign vic_idx     = vic_off[PB +: IB];
   assign vic_slot_addr = ram_base_ff + (AW'(stat.victim) << PB);
   assign hit_slot_addr = ram_base_ff + (AW'(stat.hit_slot) << PB);

   assign can_emit   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == pbsc_pkg::ST_IDLE);

   // ---------------------------------------------------------------------------
   // next state and outputs
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      tag_in        = tag_ff;
      offs_in       = offs_ff;
      new_listed_in = new_listed_ff;
      new_bank_in   = new_bank_ff;
      vic_listed_in = vic_listed_ff;
      vic_dst_in    = vic_dst_ff;
      pg_in         = pg_ff;
      count_in      = count_ff;
      walk_in       = walk_ff;
      clr_in        = clr_ff;
      emit          = 1'b0;
      kind_in       = pbsc_pkg::KIND_COPY;
      src_in        = '0;
      dst_in        = '0;
      local_in      = '0;
      hit_in        = 1'b0;
      last_in       = 1'b0;
      page_we       = 1'b0;
      page_waddr    = '0;
      page_wdata    = '0;
      page_re       = 1'b0;
      page_raddr    = new_idx;
      list_we       = 1'b0;
      list_waddr    = count_ff[IB-1:0];
      list_wdata    = vic_idx;
      list_re       = 1'b0;
      list_raddr    = walk_ff[IB-1:0];
      upd           = '0;

      unique case (state_ff)
         pbsc_pkg::ST_CLEAR: begin
            page_we    = 1'b1;
            page_waddr = clr_ff;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = pbsc_pkg::ST_IDLE;
            end
         end
         pbsc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               op_in   = req_tdata[1:0];
               tag_in  = {req_tdata[17:2+PB], PB'(0)};
               offs_in = req_tdata[2 +: PB];
               walk_in = '0;
               unique case (req_tdata[1:0])
                  pbsc_pkg::OP_COMMIT: begin
                     state_in = (count_ff == '0) ? pbsc_pkg::ST_CMT_DONE
                                                 : pbsc_pkg::ST_CMT_RD;
                  end
                  pbsc_pkg::OP_NONE: state_in = pbsc_pkg::ST_IDLE;
                  default:           state_in = pbsc_pkg::ST_LOOK;
               endcase
            end
         end
         pbsc_pkg::ST_LOOK: begin
            if (stat.hit) begin
               if (can_emit) begin
                  emit     = 1'b1;
                  kind_in  = pbsc_pkg::KIND_XLATE;
                  local_in = hit_slot_addr + AW'(offs_ff);
                  hit_in   = 1'b1;
                  last_in  = 1'b1;
                  upd.mark_dirty = (op_ff == pbsc_pkg::OP_WRITE);
                  upd.mark_slot  = stat.hit_slot;
                  state_in = pbsc_pkg::ST_IDLE;
               end
            end else begin
               page_re  = 1'b1;
               state_in = pbsc_pkg::ST_NEW_RD;
            end
         end
         pbsc_pkg::ST_NEW_RD: begin
            new_listed_in = page_rdata[1] && new_aligned;
            new_bank_in   = page_rdata[0];
            if (stat.victim_dirty) begin
               page_re    = 1'b1;
               page_raddr = vic_idx;
               state_in   = pbsc_pkg::ST_VIC_RD;
            end else begin
               state_in = pbsc_pkg::ST_FETCH;
            end
         end
         pbsc_pkg::ST_VIC_RD: begin
            vic_listed_in = page_rdata[1];
            vic_dst_in    = page_rdata[0] ? stat.victim_tag
                                          : stat.victim_tag + bank_offset_ff;
            state_in      = pbsc_pkg::ST_WB;
         end
         pbsc_pkg::ST_WB: begin
            if (can_emit) begin
               emit   = 1'b1;
               src_in = vic_slot_addr;
               dst_in = vic_dst_ff;
               // record the page in the shadow list once, keep its bank bit
               if (!vic_listed_ff) begin
                  page_we    = 1'b1;
                  page_waddr = vic_idx;
                  page_wdata = {1'b1, page_rdata[0]};
                  list_we    = 1'b1;
                  count_in   = count_ff + 1'b1;
               end
               state_in = pbsc_pkg::ST_FETCH;
            end
         end
         pbsc_pkg::ST_FETCH: begin
            if (can_emit) begin
               emit = 1'b1;
               if (new_listed_ff == new_bank_ff) begin
                  src_in = tag_ff;
               end else begin
                  src_in = tag_ff + bank_offset_ff;
               end
               dst_in   = vic_slot_addr;
               state_in = pbsc_pkg::ST_XLATE;
            end
         end
         pbsc_pkg::ST_XLATE: begin
            if (can_emit) begin
               emit           = 1'b1;
               kind_in        = pbsc_pkg::KIND_XLATE;
               local_in       = vic_slot_addr + AW'(offs_ff);
               last_in        = 1'b1;
               upd.fill       = 1'b1;
               upd.fill_dirty = (op_ff == pbsc_pkg::OP_WRITE);
               state_in       = pbsc_pkg::ST_IDLE;
            end
         end
         pbsc_pkg::ST_CMT_RD: begin
            list_re  = 1'b1;
            state_in = pbsc_pkg::ST_CMT_PG;
         end
         pbsc_pkg::ST_CMT_PG: begin
            pg_in      = list_rdata;
            page_re    = 1'b1;
            page_raddr = list_rdata;
            state_in   = pbsc_pkg::ST_CMT_WR;
         end
         pbsc_pkg::ST_CMT_WR: begin
            // flip the bank and drop the listed mark
            page_we    = 1'b1;
            page_waddr = pg_ff;
            page_wdata = {1'b0, ~page_rdata[0]};
            walk_in    = walk_ff + 1'b1;
            state_in   = (walk_in == count_ff) ? pbsc_pkg::ST_CMT_DONE
                                               : pbsc_pkg::ST_CMT_RD;
         end
         pbsc_pkg::ST_CMT_DONE: begin
            if (can_emit) begin
               emit     = 1'b1;
               kind_in  = pbsc_pkg::KIND_COMMIT;
               last_in  = 1'b1;
               count_in = '0;
               state_in = pbsc_pkg::ST_IDLE;
            end
         end
         default: state_in = pbsc_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_tready);

   // ---------------------------------------------------------------------------
   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= pbsc_pkg::ST_CLEAR;
         clr_ff          <= '0;
         count_ff        <= '0;
         walk_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         persist_base_ff <= '0;
         bank_offset_ff  <= '0;
         ram_base_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               pbsc_pkg::REG_PERSIST_BASE: persist_base_ff <= csr_wdata;
               pbsc_pkg::REG_BANK_OFFSET:  bank_offset_ff  <= csr_wdata;
               pbsc_pkg::REG_RAM_BASE:     ram_base_ff     <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      tag_ff        <= tag_in;
      offs_ff       <= offs_in;
      new_listed_ff <= new_listed_in;
      new_bank_ff   <= new_bank_in;
      vic_listed_ff <= vic_listed_in;
      vic_dst_ff    <= vic_dst_in;
      pg_ff         <= pg_in;
      if (emit) begin
         kind_ff  <= kind_in;
         src_ff   <= src_in;
         dst_ff   <= dst_in;
         local_ff <= local_in;
         hit_ff   <= hit_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, hit_ff, local_ff, dst_ff, src_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

   // ---------------------------------------------------------------------------
   // assertions
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(pbsc_pkg::PAGES))
      else $error("shadow count beyond page count");

   a_commit_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pbsc_pkg::ST_CMT_DONE && can_emit) |=> (count_ff == '0))
      else $error("commit left shadow entries");

   a_unique_tag: assert property (@(posedge clock) disable iff (reset)
      $onehot0(stat.hit_vec))
      else $error("page held in two slots");

endmodule

`default_nettype wire

@@ tb/paged_buffer_with_shadow_commit_tb.sv @@
// ----------------------------------------------------------------------------
// paged_buffer_with_shadow_commit_tb
// Self-checking bench for the page buffer translator: a scoreboard predicts
// the copy commands, translations and commit completions of every accepted
// request and checks each response transaction in order, across several
// register settings and random handshake gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module paged_buffer_with_shadow_commit_tb;

   typedef struct {
      logic [1:0]  kind;
      logic [15:0] src;
      logic [15:0] dst;
      logic [15:0] loc;
      logic        hit;
      logic        last;
   } page_rsp_type;

   // Translation predictor and queue of pending responses
   class page_scoreboard;
      logic [15:0]  persist_base, bank_offset, ram_base;
      logic [15:0]  slot_tag[pbsc_pkg::RAM_SLOTS];
      bit           slot_valid[pbsc_pkg::RAM_SLOTS];
      bit           slot_dirty[pbsc_pkg::RAM_SLOTS];
      int           repl_ptr;
      bit           bank_sel[pbsc_pkg::PAGES];
      logic [7:0]   shadow[pbsc_pkg::PAGES];
      int           shadow_cnt;
      page_rsp_type pending[$];
      int           errors, results, hits, misses, commits;

      function new();
         persist_base = 0; bank_offset = 0; ram_base = 0;
         repl_ptr = 0; shadow_cnt = 0;
         errors = 0; results = 0; hits = 0; misses = 0; commits = 0;
         for (int k = 0; k < pbsc_pkg::RAM_SLOTS; k++) begin
            slot_tag[k] = 0; slot_valid[k] = 0; slot_dirty[k] = 0;
         end
         for (int i = 0; i < pbsc_pkg::PAGES; i++) bank_sel[i] = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [15:0] val);
         case (idx)
            pbsc_pkg::REG_PERSIST_BASE: persist_base = val;
            pbsc_pkg::REG_BANK_OFFSET:  bank_offset = val;
            pbsc_pkg::REG_RAM_BASE:     ram_base = val;
            default: ;
         endcase
      endfunction

      function logic [15:0] slot_addr(int k);
         return ram_base + 16'(k * pbsc_pkg::PAGE_SIZE);
      endfunction

      function int page_index_of(logic [15:0] tag);
         logic [15:0] off;
         off = tag - persist_base;
         return (off / pbsc_pkg::PAGE_SIZE) % pbsc_pkg::PAGES;
      endfunction

      function void push(logic [1:0] kind, logic [15:0] src, logic [15:0] dst,
                         logic [15:0] loc, logic hit, logic last);
         page_rsp_type r;
         r.kind = kind; r.src = src; r.dst = dst; r.loc = loc;
         r.hit = hit; r.last = last;
         pending.push_back(r);
      endfunction

      // Predict the responses caused by one accepted request
      function void note_request(logic [1:0] op, logic [15:0] addr);
         logic [15:0] tag, offs, vt, dst, src;
         int          v, idx, vi;
         bit          listed, present;
         tag = addr & ~16'(pbsc_pkg::PAGE_SIZE - 1);
         offs = addr & 16'(pbsc_pkg::PAGE_SIZE - 1);
         listed = 0;
         present = 0;
         if (op == pbsc_pkg::OP_COMMIT) begin
            for (int i = 0; i < shadow_cnt; i++) bank_sel[shadow[i]] ^= 1'b1;
            shadow_cnt = 0;
            commits++;
            push(pbsc_pkg::KIND_COMMIT, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1);
            return;
         end
         if (op == pbsc_pkg::OP_NONE) return;
         for (int k = 0; k < pbsc_pkg::RAM_SLOTS; k++) begin
            if (slot_valid[k] && slot_tag[k] == tag) begin
               if (op == pbsc_pkg::OP_WRITE) slot_dirty[k] = 1;
               hits++;
               push(pbsc_pkg::KIND_XLATE, 16'd0, 16'd0, slot_addr(k) + offs, 1'b1, 1'b1);
               return;
            end
         end
         misses++;
         v = repl_ptr;
         idx = page_index_of(tag);
         for (int i = 0; i < shadow_cnt; i++) begin
            if (16'(shadow[i] * pbsc_pkg::PAGE_SIZE) + persist_base == tag) begin
               listed = 1;
               idx = int'(shadow[i]);
               break;
            end
         end
         // write back a dirty victim and list its page
         if (slot_valid[v] && slot_dirty[v]) begin
            vt = slot_tag[v];
            vi = page_index_of(vt);
            dst = bank_sel[vi] ? vt : vt + bank_offset;
            push(pbsc_pkg::KIND_COPY, slot_addr(v), dst, 16'd0, 1'b0, 1'b0);
            for (int i = 0; i < shadow_cnt; i++)
               if (shadow[i] == vi) begin present = 1; break; end
            if (!present && shadow_cnt < pbsc_pkg::PAGES) begin
               shadow[shadow_cnt] = 8'(vi);
               shadow_cnt++;
            end
         end
         slot_dirty[v] = 0;
         if (listed) src = bank_sel[idx] ? tag : tag + bank_offset;
         else        src = bank_sel[idx] ? tag + bank_offset : tag;
         push(pbsc_pkg::KIND_COPY, src, slot_addr(v), 16'd0, 1'b0, 1'b0);
         slot_tag[v] = tag;
         slot_valid[v] = 1;
         if (op == pbsc_pkg::OP_WRITE) slot_dirty[v] = 1;
         repl_ptr = (v + 1) % pbsc_pkg::RAM_SLOTS;
         push(pbsc_pkg::KIND_XLATE, 16'd0, 16'd0, slot_addr(v) + offs, 1'b0, 1'b1);
      endfunction

      // Compare one response transaction with the oldest prediction
      function void check_response(page_rsp_type act);
         page_rsp_type e;
         results++;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected response kind=%0d src=%h dst=%h loc=%h hit=%b last=%b",
                     $time, act.kind, act.src, act.dst, act.loc, act.hit, act.last);
            return;
         end
         e = pending.pop_front();
         if (e.kind !== act.kind) report("kind", 16'(e.kind), 16'(act.kind));
         if (e.src !== act.src) report("copy_source", e.src, act.src);
         if (e.dst !== act.dst) report("copy_dest", e.dst, act.dst);
         if (e.loc !== act.loc) report("local_address", e.loc, act.loc);
         if (e.hit !== act.hit) report("was_hit", 16'(e.hit), 16'(act.hit));
         if (e.last !== act.last) report("last", 16'(e.last), 16'(act.last));
      endfunction

      function void report(string field, logic [15:0] exp_v, logic [15:0] act_v);
         errors++;
         $display("%0t: %s mismatch expected %h actual %h", $time, field, exp_v, act_v);
      endfunction
   endclass

   logic        clock = 0;
   logic        reset;
   logic        req_tvalid, req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid, rsp_tready;
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   page_scoreboard sb = new();
   int  idle_cycles = 0;
   bit  timed_out = 0;
   bit  no_gaps = 0;
   int  items = 0;
   logic [15:0] tag_pool[12];

   paged_buffer_with_shadow_commit i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial forever #4 clock = ~clock;

   // Gap length: mostly none or short, a few long
   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Sink side: check each response transaction, stall at random
   always @(posedge clock) begin
      page_rsp_type act;
      if (!reset && rsp_tvalid && rsp_tready) begin
         act.kind = rsp_tuser;
         act.src = rsp_tdata[15:0];
         act.dst = rsp_tdata[31:16];
         act.loc = rsp_tdata[47:32];
         act.hit = rsp_tdata[48];
         act.last = rsp_tlast;
         sb.check_response(act);
      end
      if (reset) rsp_tready <= 1'b0;
      else       rsp_tready <= (pick_gap() == 0);
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 6000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send(logic [1:0] op, logic [15:0] addr);
      int gap;
      req_tvalid <= 1;
      req_tdata <= {6'd0, addr, op};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, addr);
      items++;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drain all pending responses, then let the block settle
   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   task automatic configure(logic [15:0] pb, logic [15:0] bo, logic [15:0] rb);
      write_reg(pbsc_pkg::REG_PERSIST_BASE, pb);
      write_reg(pbsc_pkg::REG_BANK_OFFSET, bo);
      write_reg(pbsc_pkg::REG_RAM_BASE, rb);
      // pool of pages near the region start so the shadow list gets reused
      for (int i = 0; i < 12; i++)
         tag_pool[i] = pb + 16'(($urandom_range(0, 15)) * pbsc_pkg::PAGE_SIZE);
   endtask

   // Random traffic: mostly pooled pages, some arbitrary addresses
   task automatic random_phase(int count);
      int r;
      logic [1:0] op;
      logic [15:0] addr;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 45) op = pbsc_pkg::OP_READ;
         else if (r < 87) op = pbsc_pkg::OP_WRITE;
         else if (r < 96) op = pbsc_pkg::OP_COMMIT;
         else op = pbsc_pkg::OP_NONE;
         if ($urandom_range(0, 9) < 8)
            addr = tag_pool[$urandom_range(0, 11)]
                   | 16'($urandom_range(0, pbsc_pkg::PAGE_SIZE - 1));
         else
            addr = 16'($urandom);
         send(op, addr);
      end
   endtask

   initial begin
      reset <= 1;
      req_tvalid <= 0;
      req_tdata <= 0;
      csr_wr_en <= 0;
      csr_index <= 0;
      csr_wdata <= 0;
      repeat (6) @(posedge clock);
      reset <= 0;

      // Directed: reset registers, page 0 as a real page, extremes, eviction
      no_gaps = 1;
      send(pbsc_pkg::OP_COMMIT, 16'h0000);
      send(pbsc_pkg::OP_NONE, 16'hFFFF);
      send(pbsc_pkg::OP_READ, 16'h0000);
      send(pbsc_pkg::OP_WRITE, 16'h003F);
      send(pbsc_pkg::OP_READ, 16'hFFFF);
      send(pbsc_pkg::OP_WRITE, 16'hFFC0);
      for (int i = 1; i <= 8; i++)
         send(pbsc_pkg::OP_WRITE, 16'(i * pbsc_pkg::PAGE_SIZE) + 16'(i));
      send(pbsc_pkg::OP_READ, 16'h0010);
      send(pbsc_pkg::OP_COMMIT, 16'h1234);
      send(pbsc_pkg::OP_READ, 16'hFFC5);
      send(pbsc_pkg::OP_WRITE, 16'h0040);
      send(pbsc_pkg::OP_NONE, 16'h0000);
      send(pbsc_pkg::OP_READ, 16'h8000);
      drain();

      // Extreme register values, then mid and random settings
      no_gaps = 0;
      configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send(pbsc_pkg::OP_WRITE, 16'hFFFF);
      send(pbsc_pkg::OP_WRITE, 16'h0000);
      random_phase(100);
      drain();
      configure(16'h1000, 16'h8000, 16'hC000);
      random_phase(110);
      drain();
      no_gaps = 1;
      configure(16'($urandom), 16'($urandom), 16'($urandom));
      random_phase(60);
      drain();
      no_gaps = 0;
      configure(16'h0000, 16'h5555, 16'hAAAA);
      random_phase(140);
      drain();
      repeat (30) @(posedge clock);

      $display("Covered %0d requests: %0d hits, %0d misses, %0d commits, %0d responses.",
               items, sb.hits, sb.misses, sb.commits, sb.results);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
